// File: rtl/core/bcbp_pkg.sv
`timescale 1ns / 1ps
// Package holding the shared types and constants of the canonical block parser.
package bcbp_pkg;

    localparam int unsigned STATUS_W = 4;
    localparam int unsigned COUNT_W  = 33;

    typedef enum logic [3:0] {
        ST_BUSY         = 4'd0,
        ST_PAYLOAD      = 4'd1,
        ST_OK           = 4'd2,
        ST_ARRAY_HDR    = 4'd3,
        ST_TYPE_ENC     = 4'd4,
        ST_INT_ENC      = 4'd5,
        ST_CRC_TYPE     = 4'd6,
        ST_BSTR_HDR     = 4'd7,
        ST_TRUNCATED    = 4'd8,
        ST_CRC_FIELD    = 4'd9,
        ST_CRC_MISMATCH = 4'd10,
        ST_TOO_LONG     = 4'd11
    } t_status;

    typedef enum logic [13:0] {
        PH_ARRAY     = 14'b00000000000001,
        PH_TYPE_HEAD = 14'b00000000000010,
        PH_TYPE_EXT  = 14'b00000000000100,
        PH_NUM_HEAD  = 14'b00000000001000,
        PH_NUM_EXT   = 14'b00000000010000,
        PH_FLAG_HEAD = 14'b00000000100000,
        PH_FLAG_EXT  = 14'b00000001000000,
        PH_CRC_TYPE  = 14'b00000010000000,
        PH_BSTR_HEAD = 14'b00000100000000,
        PH_BSTR_EXT  = 14'b00001000000000,
        PH_PAYLOAD   = 14'b00010000000000,
        PH_CRC_HEAD  = 14'b00100000000000,
        PH_CRC_VAL   = 14'b01000000000000,
        PH_IDLE      = 14'b10000000000000
    } t_phase;

    localparam logic [2:0]  MT_UINT       = 3'd0;
    localparam logic [2:0]  MT_BSTR       = 3'd2;
    localparam logic [2:0]  MT_ARRAY      = 3'd4;
    localparam logic [4:0]  AI_ONE_BYTE   = 5'd24;
    localparam logic [4:0]  AI_MAX        = 5'd27;
    localparam logic [7:0]  CRC_NONE      = 8'd0;
    localparam logic [7:0]  CRC_X25       = 8'd1;
    localparam logic [7:0]  CRC_32C       = 8'd2;
    localparam logic [7:0]  CRC16_HEAD    = 8'h42;
    localparam logic [7:0]  CRC32_HEAD    = 8'h44;
    localparam logic [15:0] CRC16_POLY    = 16'h8408;
    localparam logic [31:0] CRC32_POLY    = 32'h82F63B78;

    // One classified input byte as passed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       last;
    } t_item;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/bundle_canonical_block_parser_core.sv
`timescale 1ns / 1ps
// Canonical block parser: how to use it.
// Input channel: push a byte with block_start and buffer_last while full is low.
// Every byte accepted gives exactly one result item with a status, the byte
// when it is payload, and the block fields decoded so far.
// Result channel: a result is on the output ports while empty is low and is
// taken when pop is high. A byte passes first through the two-entry input
// queue and then through the parser, whose result register feeds the output.
// Throughput is one byte per cycle while results are popped, set by the
// combinational field decoder and bytewise CRC update; the parser advances
// whenever its result register is free or being popped in the same cycle.
// When the receiver stalls, the result register holds, the parser waits, and
// the input queue fills; full then rises after two further bytes.
// The CRC-check skip register is written on its own valid/ready channel; ready is
// always high. Write it only while the block is idle; the block does not check this.
// Reset is synchronous and active low; it empties both queues, restarts the
// parse at the array header and clears the skip register.
module bundle_canonical_block_parser_core import bcbp_pkg::*; #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_block_start,
    input  logic        i_buffer_last,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_status,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_block_type,
    output logic [63:0] o_block_number,
    output logic [63:0] o_control_flags,
    output logic [7:0]  o_crc_kind,
    output logic [31:0] o_payload_length,
    output logic [31:0] o_received_crc,
    output logic [32:0] o_bytes_taken,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_skip_crc_check
);

    t_item w_in;
    t_item w_q;
    logic  w_qvalid;
    logic  w_take;
    logic  r_skip;

    assign w_in = '{data: i_data_byte, start: i_block_start, last: i_buffer_last};
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b0;
        end else if (i_cfg_valid) begin
            r_skip <= i_cfg_skip_crc_check;
        end
    end

    bcbp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (w_in),
        .o_valid (w_qvalid),
        .o_item  (w_q),
        .i_take  (w_take)
    );

    bcbp_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_skip           (r_skip),
        .i_valid          (w_qvalid),
        .i_item           (w_q),
        .o_take           (w_take),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_status         (o_status),
        .o_payload_byte   (o_payload_byte),
        .o_block_type     (o_block_type),
        .o_block_number   (o_block_number),
        .o_control_flags  (o_control_flags),
        .o_crc_kind       (o_crc_kind),
        .o_payload_length (o_payload_length),
        .o_received_crc   (o_received_crc),
        .o_bytes_taken    (o_bytes_taken)
    );

endmodule

// File: rtl/core/bcbp_front.sv
`timescale 1ns / 1ps
// Input queue: accepts bytes from the push side and holds them for the parser.
module bcbp_front import bcbp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: rtl/core/bcbp_back.sv
`timescale 1ns / 1ps
// Parser back end: CBOR field decoding, CRC update and the result register.
module bcbp_back import bcbp_pkg::*; #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_skip,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_take,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [3:0]  o_status,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_block_type,
    output logic [63:0] o_block_number,
    output logic [63:0] o_control_flags,
    output logic [7:0]  o_crc_kind,
    output logic [31:0] o_payload_length,
    output logic [31:0] o_received_crc,
    output logic [32:0] o_bytes_taken
);

    t_phase       r_phase, n_phase;
    logic [3:0]   r_fcnt, n_fcnt;
    logic [63:0]  r_acc, n_acc;
    logic [2:0]   r_alen, n_alen;
    logic [7:0]   r_btype, n_btype;
    logic [63:0]  r_bnum, n_bnum;
    logic [63:0]  r_flags, n_flags;
    logic [7:0]   r_ckind, n_ckind;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [31:0]  r_rcrc, n_rcrc;
    logic [15:0]  r_c16, n_c16;
    logic [31:0]  r_c32, n_c32;
    logic [COUNT_W-1:0] r_bcnt, n_bcnt;
    logic         r_ovalid;
    t_status      n_st;
    logic         n_pay;

    t_phase       w_ph;
    logic [15:0]  w_c16;
    logic [31:0]  w_c32;
    logic [COUNT_W-1:0] w_bcnt;
    logic [2:0]   w_alen;
    logic [63:0]  w_acc;
    logic [3:0]   w_fcnt;
    logic [7:0]   w_btype, w_ckind;
    logic [63:0]  w_bnum, w_flags;
    logic [LENGTH_BITS-1:0] w_len, w_rem;
    logic [31:0]  w_rcrc;
    logic [7:0]   b;
    logic [4:0]   ai;
    logic [2:0]   mt;
    logic [63:0]  ext;
    logic [31:0]  calc;
    logic         step;
    logic         len_ok;
    logic         go_len;

    assign o_take = i_valid && (!r_ovalid || i_pop);
    assign step   = o_take;
    assign o_empty = !r_ovalid;
    assign b  = i_item.data;
    assign ai = b[4:0];
    assign mt = b[7:5];

    always_comb begin
        // Block start clears the parse state before the byte is applied.
        w_ph    = i_item.start ? PH_ARRAY : r_phase;
        w_c16   = i_item.start ? 16'hFFFF : r_c16;
        w_c32   = i_item.start ? 32'hFFFFFFFF : r_c32;
        w_bcnt  = i_item.start ? '0 : r_bcnt;
        w_alen  = i_item.start ? '0 : r_alen;
        w_acc   = i_item.start ? '0 : r_acc;
        w_fcnt  = i_item.start ? '0 : r_fcnt;
        w_btype = i_item.start ? '0 : r_btype;
        w_bnum  = i_item.start ? '0 : r_bnum;
        w_flags = i_item.start ? '0 : r_flags;
        w_ckind = i_item.start ? '0 : r_ckind;
        w_len   = i_item.start ? '0 : r_len;
        w_rem   = i_item.start ? '0 : r_rem;
        w_rcrc  = i_item.start ? '0 : r_rcrc;

        n_phase = w_ph;  n_c16 = w_c16;  n_c32 = w_c32;  n_bcnt = w_bcnt;
        n_alen = w_alen; n_acc = w_acc;  n_fcnt = w_fcnt; n_btype = w_btype;
        n_bnum = w_bnum; n_flags = w_flags; n_ckind = w_ckind; n_len = w_len;
        n_rem = w_rem;   n_rcrc = w_rcrc;
        n_st = ST_BUSY;
        n_pay = 1'b0;
        ext = {w_acc[55:0], b};
        calc = '0;
        len_ok = 1'b0;
        go_len = 1'b0;

        if (w_ph != PH_IDLE) begin
            n_c16 = crc16_byte(w_c16, (w_ph == PH_CRC_VAL) ? 8'd0 : b);
            n_c32 = crc32_byte(w_c32, (w_ph == PH_CRC_VAL) ? 8'd0 : b);
            calc = (w_ckind == CRC_X25) ? {16'd0, n_c16 ^ 16'hFFFF} : (n_c32 ^ 32'hFFFFFFFF);
            if (w_bcnt != {COUNT_W{1'b1}}) begin
                n_bcnt = w_bcnt + 1'b1;
            end
            unique case (w_ph)
                PH_ARRAY: begin
                    if (mt != MT_ARRAY || (ai != 5'd5 && ai != 5'd6)) begin
                        n_st = ST_ARRAY_HDR;
                    end else begin
                        n_alen = ai[2:0];
                        n_phase = PH_TYPE_HEAD;
                    end
                end
                PH_TYPE_HEAD, PH_NUM_HEAD, PH_FLAG_HEAD, PH_BSTR_HEAD: begin
                    if (mt != ((w_ph == PH_BSTR_HEAD) ? MT_BSTR : MT_UINT)
                        || ai > ((w_ph == PH_TYPE_HEAD) ? AI_ONE_BYTE : AI_MAX)) begin
                        unique case (w_ph)
                            PH_TYPE_HEAD: n_st = ST_TYPE_ENC;
                            PH_BSTR_HEAD: n_st = ST_BSTR_HDR;
                            default:      n_st = ST_INT_ENC;
                        endcase
                    end else if (ai < AI_ONE_BYTE) begin
                        n_acc = {59'd0, ai};
                        n_fcnt = '0;
                        unique case (w_ph)
                            PH_TYPE_HEAD: begin
                                n_btype = {3'd0, ai};
                                n_phase = PH_NUM_HEAD;
                            end
                            PH_NUM_HEAD: begin
                                n_bnum = {59'd0, ai};
                                n_phase = PH_FLAG_HEAD;
                            end
                            PH_FLAG_HEAD: begin
                                n_flags = {59'd0, ai};
                                n_phase = PH_CRC_TYPE;
                            end
                            default: go_len = 1'b1;
                        endcase
                    end else begin
                        n_acc = '0;
                        n_fcnt = 4'd1 << (ai[1:0]);
                        unique case (w_ph)
                            PH_TYPE_HEAD: n_phase = PH_TYPE_EXT;
                            PH_NUM_HEAD:  n_phase = PH_NUM_EXT;
                            PH_FLAG_HEAD: n_phase = PH_FLAG_EXT;
                            default:      n_phase = PH_BSTR_EXT;
                        endcase
                    end
                end
                PH_TYPE_EXT, PH_NUM_EXT, PH_FLAG_EXT, PH_BSTR_EXT, PH_CRC_VAL: begin
                    n_acc = ext;
                    n_fcnt = w_fcnt - 4'd1;
                    if (w_fcnt == 4'd1) begin
                        unique case (w_ph)
                            PH_TYPE_EXT: begin
                                n_btype = b;
                                n_phase = PH_NUM_HEAD;
                            end
                            PH_NUM_EXT: begin
                                n_bnum = ext;
                                n_phase = PH_FLAG_HEAD;
                            end
                            PH_FLAG_EXT: begin
                                n_flags = ext;
                                n_phase = PH_CRC_TYPE;
                            end
                            PH_BSTR_EXT: go_len = 1'b1;
                            default: begin
                                n_rcrc = ext[31:0];
                                n_st = (i_skip || calc == ext[31:0]) ? ST_OK : ST_CRC_MISMATCH;
                            end
                        endcase
                    end
                end
                PH_CRC_TYPE: begin
                    if (b > CRC_32C || ((w_alen == 3'd6) != (b != CRC_NONE))) begin
                        n_st = ST_CRC_TYPE;
                    end else begin
                        n_ckind = b;
                        n_phase = PH_BSTR_HEAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_st = ST_PAYLOAD;
                    n_pay = 1'b1;
                    n_rem = w_rem - 1'b1;
                    if (w_rem == {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
                        if (w_ckind == CRC_NONE) begin
                            n_st = ST_OK;
                        end else begin
                            n_phase = PH_CRC_HEAD;
                        end
                    end
                end
                PH_CRC_HEAD: begin
                    if (b != ((w_ckind == CRC_X25) ? CRC16_HEAD : CRC32_HEAD)) begin
                        n_st = ST_CRC_FIELD;
                    end else begin
                        n_acc = '0;
                        n_fcnt = (w_ckind == CRC_X25) ? 4'd2 : 4'd4;
                        n_phase = PH_CRC_VAL;
                    end
                end
                default: begin
                end
            endcase

            if (go_len) begin
                if (LENGTH_BITS < 64) begin
                    len_ok = ((n_acc >> LENGTH_BITS) == 64'd0);
                end else begin
                    len_ok = 1'b1;
                end
                if (!len_ok) begin
                    n_st = ST_TOO_LONG;
                end else begin
                    n_len = n_acc[LENGTH_BITS-1:0];
                    n_rem = n_acc[LENGTH_BITS-1:0];
                    if (n_acc[LENGTH_BITS-1:0] == '0) begin
                        if (w_ckind == CRC_NONE) begin
                            n_st = ST_OK;
                        end else begin
                            n_phase = PH_CRC_HEAD;
                        end
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end

            if (n_st != ST_BUSY && n_st != ST_PAYLOAD) begin
                n_phase = PH_IDLE;
            end else if (i_item.last) begin
                n_st = ST_TRUNCATED;
                n_pay = 1'b0;
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ARRAY;
            r_fcnt   <= '0;
            r_acc    <= '0;
            r_alen   <= '0;
            r_btype  <= '0;
            r_bnum   <= '0;
            r_flags  <= '0;
            r_ckind  <= '0;
            r_len    <= '0;
            r_rem    <= '0;
            r_rcrc   <= '0;
            r_c16    <= 16'hFFFF;
            r_c32    <= 32'hFFFFFFFF;
            r_bcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (step) begin
                r_phase <= n_phase;
                r_fcnt  <= n_fcnt;
                r_acc   <= n_acc;
                r_alen  <= n_alen;
                r_btype <= n_btype;
                r_bnum  <= n_bnum;
                r_flags <= n_flags;
                r_ckind <= n_ckind;
                r_len   <= n_len;
                r_rem   <= n_rem;
                r_rcrc  <= n_rcrc;
                r_c16   <= n_c16;
                r_c32   <= n_c32;
                r_bcnt  <= n_bcnt;
            end
            if (step) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            o_status         <= n_st;
            o_payload_byte   <= n_pay ? b : 8'd0;
            o_block_type     <= n_btype;
            o_block_number   <= n_bnum;
            o_control_flags  <= n_flags;
            o_crc_kind       <= n_ckind;
            o_payload_length <= 32'(n_len);
            o_received_crc   <= n_rcrc;
            o_bytes_taken    <= (n_st == ST_OK || n_st == ST_CRC_MISMATCH) ? n_bcnt : '0;
        end
    end

endmodule

// File: rtl/core/bcbp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the canonical block parser, with its bind statement.
module bcbp_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  o_status,
    input logic [7:0]  o_payload_byte,
    input logic [32:0] o_bytes_taken
);

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_status <= 4'd11) else $error("Status out of range.");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != 4'd1 && o_status != 4'd2) |-> o_payload_byte == 8'd0)
        else $error("Payload byte set without payload status.");

    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != 4'd2 && o_status != 4'd10) |-> o_bytes_taken == '0)
        else $error("Byte count shown without a completed block.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status)))
        else $error("Result item changed while stalled.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full)) else $error("Queues not empty after reset.");

endmodule

bind bundle_canonical_block_parser_core bcbp_props u_bcbp_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_status       (o_status),
    .o_payload_byte (o_payload_byte),
    .o_bytes_taken  (o_bytes_taken)
);
